// ===== src/rlm_pkg.sv =====
// Shared constants for the RMS level meter.
`timescale 1ns / 1ps
`default_nettype none
package rlm_pkg;

  localparam int unsigned LOG_FRAC_W      = 24;
  localparam int unsigned FULL_SCALE_LOG2 = 30;
  localparam int unsigned FULL_SCALE_Q    = FULL_SCALE_LOG2 << LOG_FRAC_W;
  localparam int unsigned DB_K_W          = 26;
  localparam logic [DB_K_W-1:0] DB_PER_LOG2_Q16 = 26'd50504453;
  localparam int unsigned ROUND_SHIFT     = 40;
  localparam logic [63:0] ROUND_HALF      = 64'd1 << (ROUND_SHIFT - 1);
  localparam logic [16:0] LEVEL_MAG_MAX   = 17'd32768;
  localparam logic [15:0] LEVEL_ZERO_BLK  = 16'hA000;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned SQUARE_W        = 31;

endpackage
`default_nettype wire

// ===== src/rlm_log2.sv =====
// Multi-cycle log2 unit: bit-serial normalize, then one squaring step per fraction bit.
`timescale 1ns / 1ps
`default_nettype none
module rlm_log2 #(
  parameter int unsigned W = 43,
  localparam int unsigned RW = $clog2(W) + rlm_pkg::LOG_FRAC_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  x_i,
  output logic               done_o,
  output logic [RW-1:0]      result_o
);
  import rlm_pkg::*;

  localparam int unsigned NW  = W + 32;
  localparam int unsigned EW  = $clog2(W);
  localparam int unsigned IW  = $clog2(LOG_FRAC_W);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_FRAC = 2'd2;

  logic [1:0]            state_q;
  logic [NW-1:0]         n_q;
  logic [EW-1:0]         e_q;
  logic [31:0]           m_q;
  logic [LOG_FRAC_W-1:0] frac_q;
  logic [IW-1:0]         iter_q;
  logic                  done_q;
  logic [63:0]           sq;
  logic [31:0]           m_d;

  assign sq  = m_q * m_q;
  assign m_d = sq[63] ? sq[63:32] : sq[62:31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (n_q[NW-1]) begin
            state_q <= L_FRAC;
          end
        end
        L_FRAC: begin
          if (iter_q == IW'(LOG_FRAC_W - 1)) begin
            state_q <= L_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          n_q <= {x_i, 32'd0};
          e_q <= EW'(W - 1);
        end
      end
      L_NORM: begin
        if (n_q[NW-1]) begin
          m_q    <= n_q[NW-1 -: 32];
          iter_q <= '0;
        end else begin
          n_q <= {n_q[NW-2:0], 1'b0};
          e_q <= e_q - EW'(1);
        end
      end
      L_FRAC: begin
        m_q    <= m_d;
        frac_q <= {frac_q[LOG_FRAC_W-2:0], sq[63]};
        iter_q <= iter_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = {e_q, frac_q};

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == L_NORM |-> n_q != '0)
    else $error("log2 normalize started on zero");

endmodule
`default_nettype wire

// ===== src/rlm_front.sv =====
// Front end: accepts samples, accumulates squares and counts, forms queue entries.
`timescale 1ns / 1ps
`default_nettype none
module rlm_front #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 4096,
  parameter int unsigned CNT_W = 13,
  parameter int unsigned SUM_W = 43
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               last_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output logic [SUM_W-1:0]        sum_o,
  output logic [CNT_W-1:0]        cnt_o
);
  import rlm_pkg::*;

  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [31:0] sq;
  logic               below_max;

  assign sq        = sample_i * sample_i;
  assign below_max = cnt_q < CNT_W'(MAX_BLOCK_SAMPLES);
  assign sum_o     = below_max ? sum_q + SUM_W'(sq[SQUARE_W-1:0]) : sum_q;
  assign cnt_o     = below_max ? cnt_q + CNT_W'(1) : cnt_q;
  assign stall_o   = full_i;
  assign push_o    = valid_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (push_o) begin
      if (last_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_o;
        cnt_q <= cnt_o;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/rlm_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module rlm_queue #(
  parameter int unsigned DATA_W = 73
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o,
  input  wire logic              pop_i
);
  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [PTR_W:0]    fill_q;

  assign full_o  = fill_q == (PTR_W + 1)'(DEPTH);
  assign valid_o = fill_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== src/rlm_back.sv =====
// Back end: block level computation and the output register.
`timescale 1ns / 1ps
`default_nettype none
module rlm_back #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned SUM_W = 43,
  localparam int unsigned ENTRY_W = 17 + SUM_W + CNT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire logic [ENTRY_W-1:0] q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_out_o,
  output logic                    level_valid_o,
  output logic signed [15:0]      level_db_o
);
  import rlm_pkg::*;

  localparam int unsigned RW    = $clog2(SUM_W) + LOG_FRAC_W;
  localparam int unsigned DW    = RW + 2;
  localparam int unsigned MAG_W = RW + 1;
  localparam int unsigned PW    = MAG_W + DB_K_W;
  localparam int unsigned QW    = PW + 1 - ROUND_SHIFT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LSUM = 3'd1;
  localparam logic [2:0] S_LCNT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_q;
  logic [15:0]        sample_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RW-1:0]      ls_q;
  logic [MAG_W-1:0]   mag_q;
  logic [PW-1:0]      prod_q;
  logic [15:0]        level_q;
  logic               out_valid_q;
  logic               out_valid_d;
  logic [15:0]        sample_out_q;
  logic               level_valid_q;
  logic [15:0]        level_db_q;

  logic [15:0]        e_sample;
  logic               e_last;
  logic [SUM_W-1:0]   e_sum;
  logic [CNT_W-1:0]   e_cnt;
  logic               can_load;
  logic               out_load;
  logic               zero_blk;
  logic               log_start;
  logic [SUM_W-1:0]   log_x;
  logic               log_done;
  logic [RW-1:0]      log_res;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] neg_diff;
  logic [PW-1:0]      mult;
  logic [PW:0]        rnd;
  logic [QW-1:0]      q;
  logic [16:0]        q_sat;
  logic [16:0]        neg_level;

  assign {e_sample, e_last, e_sum, e_cnt} = q_data_i;

  assign can_load = !out_valid_q || !out_stall_i;
  assign zero_blk = (e_sum == '0) || (e_cnt == '0);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i && (e_last || can_load);
  assign out_load = (q_pop_o && !e_last) || ((state_q == S_OUT) && can_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);
  assign log_start = (q_pop_o && e_last && !zero_blk) || (state_q == S_LSUM && log_done);
  assign log_x     = (state_q == S_IDLE) ? e_sum : SUM_W'(cnt_q);

  rlm_log2 #(
    .W (SUM_W)
  ) u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .done_o   (log_done),
    .result_o (log_res)
  );

  assign diff = $signed({2'b00, ls_q}) - $signed({2'b00, log_res})
              - $signed(DW'(FULL_SCALE_Q));
  assign neg_diff = -diff;
  assign mult  = mag_q * DB_PER_LOG2_Q16;
  assign rnd   = {1'b0, prod_q} + (PW + 1)'(ROUND_HALF);
  assign q     = rnd[PW:ROUND_SHIFT];
  assign q_sat = (q > QW'(LEVEL_MAG_MAX)) ? LEVEL_MAG_MAX : q[16:0];
  assign neg_level = 17'd0 - q_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (q_pop_o && e_last) begin
            if (zero_blk) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_LSUM;
            end
          end
        end
        S_LSUM: begin
          if (log_done) begin
            state_q <= S_LCNT;
          end
        end
        S_LCNT: begin
          if (log_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_RND;
        end
        S_RND: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          sample_q <= e_sample;
          cnt_q    <= e_cnt;
          level_q  <= LEVEL_ZERO_BLK;
          if (!e_last) begin
            sample_out_q  <= e_sample;
            level_valid_q <= 1'b0;
            level_db_q    <= '0;
          end
        end
      end
      S_LSUM: begin
        if (log_done) begin
          ls_q <= log_res;
        end
      end
      S_LCNT: begin
        if (log_done) begin
          mag_q <= diff[DW-1] ? neg_diff[MAG_W-1:0] : '0;
        end
      end
      S_MUL: begin
        prod_q <= mult;
      end
      S_RND: begin
        level_q <= neg_level[15:0];
      end
      S_OUT: begin
        if (can_load) begin
          sample_out_q  <= sample_q;
          level_valid_q <= 1'b1;
          level_db_q    <= level_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign level_valid_o = level_valid_q;
  assign level_db_o    = level_db_q;

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  a_plain_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !level_valid_o |-> level_db_o == 16'sd0)
    else $error("level on a non-final sample");

  a_level_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && level_valid_o |-> level_db_o[15] || level_db_o == 16'sd0)
    else $error("positive block level");

endmodule
`default_nettype wire

// ===== src/rms_level_meter_dbfs_top.sv =====
// Top level of the block RMS level meter with sample pass-through.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  sample_i, last_of_block_i
//   out      output     out_valid_o / out_stall_i sample_out_o, level_valid_o, level_db_o
//
// A non-final sample passes through the queue into the output register, one per cycle
// while the back end is idle and the output does not stall. A block-end sample holds the
// back end for two serial log2 runs (normalize shift, 24 squarings), multiply, round and
// output; an all-zero block goes straight to output.
// Reset clears the accumulator, counter, queue and all control state; no clearing pass.
// Output stall holds the output register; the input stalls once the queue holds two.
`timescale 1ns / 1ps
`default_nettype none
module rms_level_meter_dbfs_top #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               last_of_block_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_out_o,
  output logic                    level_valid_o,
  output logic signed [15:0]      level_db_o
);
  import rlm_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SUM_W   = FULL_SCALE_LOG2 + CNT_W;
  localparam int unsigned ENTRY_W = SAMPLE_W + 1 + SUM_W + CNT_W;

  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  logic [SUM_W-1:0]   f_sum;
  logic [CNT_W-1:0]   f_cnt;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  rlm_front #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
    .CNT_W             (CNT_W),
    .SUM_W             (SUM_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .sample_i (sample_i),
    .last_i   (last_of_block_i),
    .full_i   (q_full),
    .push_o   (q_push),
    .sum_o    (f_sum),
    .cnt_o    (f_cnt)
  );

  assign q_wdata = {sample_i, last_of_block_i, f_sum, f_cnt};

  rlm_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  rlm_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .level_valid_o (level_valid_o),
    .level_db_o    (level_db_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the block RMS level meter with sample pass-through.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned     BLOCK_BOUND    = 4096;
  localparam int unsigned     FRAC_W         = 24;
  localparam longint unsigned FULL_SCALE_Q   = 64'd30 << FRAC_W;
  localparam longint unsigned DB_PER_OCTAVE  = 64'd50504453;
  localparam int unsigned     DB_SHIFT       = 40;
  localparam longint unsigned DB_ROUND       = 64'd1 << (DB_SHIFT - 1);
  localparam longint unsigned DB_MAG_LIMIT   = 64'd32768;
  localparam logic signed [15:0] SILENT_LEVEL = -16'sd24576;
  localparam int unsigned     RANDOM_ITEMS   = 1850;
  localparam int unsigned     SQUEEZE_CYCLES = 300;
  localparam int unsigned     QUIET_LIMIT    = 3000;
  localparam int unsigned     DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               lvl_valid;
    logic signed [15:0] lvl_db;
  } meter_result_t;

  class level_scoreboard;
    logic [42:0]        sum_sq;
    logic [12:0]        n_in_block;
    meter_result_t      pending[$];
    int unsigned        errors;
    int unsigned        n_samples;
    int unsigned        n_blocks;
    logic signed [15:0] lowest;
    logic signed [15:0] highest;

    function new();
      sum_sq     = '0;
      n_in_block = '0;
      errors     = 0;
      n_samples  = 0;
      n_blocks   = 0;
      lowest     = 16'sd0;
      highest    = 16'sh8000;
    endfunction

    function logic [63:0] log2_fixed(logic [63:0] x);
      int unsigned e;
      logic [63:0] t;
      logic [63:0] m;
      logic [23:0] frac;
      e = 0;
      t = x;
      frac = '0;
      while (t > 1) begin
        t = t >> 1;
        e++;
      end
      if (e >= 31) m = x >> (e - 31);
      else m = x << (31 - e);
      for (int i = 0; i < FRAC_W; i++) begin
        m = (m * m) >> 31;
        frac = {frac[22:0], m[32]};
        if (m[32]) m = m >> 1;
      end
      return (64'(e) << FRAC_W) | 64'(frac);
    endfunction

    function logic signed [15:0] level_of_block();
      longint d;
      logic [63:0] mag;
      logic [63:0] q;
      if (sum_sq == 0 || n_in_block == 0) return SILENT_LEVEL;
      d = longint'(log2_fixed(64'(sum_sq))) - longint'(log2_fixed(64'(n_in_block)))
          - longint'(FULL_SCALE_Q);
      if (d > 0) d = 0;
      mag = 64'(-d);
      q = (mag * DB_PER_OCTAVE + DB_ROUND) >> DB_SHIFT;
      if (q > DB_MAG_LIMIT) q = DB_MAG_LIMIT;
      return 16'(64'd0 - q);
    endfunction

    function void note_input(logic signed [15:0] s, logic last);
      meter_result_t r;
      longint sq;
      sq = longint'(s) * longint'(s);
      if (n_in_block < BLOCK_BOUND) begin
        sum_sq = sum_sq + 43'(sq);
        n_in_block = n_in_block + 13'd1;
      end
      r.sample    = s;
      r.lvl_valid = last;
      r.lvl_db    = 16'sd0;
      if (last) begin
        r.lvl_db = level_of_block();
        sum_sq = '0;
        n_in_block = '0;
        n_blocks++;
        if (r.lvl_db < lowest) lowest = r.lvl_db;
        if (r.lvl_db > highest) highest = r.lvl_db;
      end
      n_samples++;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] s, logic lv, logic signed [15:0] db);
      meter_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected output transaction: sample_out %0d", s);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (s !== r.sample) begin
        $error("sample_out mismatch: expected %0d, actual %0d", r.sample, s);
        errors++;
      end
      if (lv !== r.lvl_valid) begin
        $error("level_valid mismatch: expected %0d, actual %0d", r.lvl_valid, lv);
        errors++;
      end
      if (db !== r.lvl_db) begin
        $error("level_db mismatch: expected %0d, actual %0d", r.lvl_db, db);
        errors++;
      end
    endfunction
  endclass

  bit                 clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample = '0;
  logic               last_of_block = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic               level_valid;
  logic signed [15:0] level_db;

  bit          calm = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  level_scoreboard sb = new();

  rms_level_meter_dbfs_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .last_of_block_i(last_of_block),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_out_o   (sample_out),
    .level_valid_o  (level_valid),
    .level_db_o     (level_db)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_sample(input logic signed [15:0] s, input logic last);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample        <= s;
    last_of_block <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(s, last);
    @(negedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(sample_out, level_valid, level_db);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned shift;
    bit          silent;
    logic signed [15:0] v;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single-sample and short blocks at the extremes, silence, smallest nonzero
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(16'sh8000, i == 3);
    send_sample(-16'sd128, 1'b0);
    send_sample(16'sd127, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
      silent = ($urandom_range(99) < 6);
      shift = $urandom_range(15, 0);
      for (int i = 0; i < len; i++) begin
        calm = (sent >= 900 && sent < 1200);
        if (sent == 500) squeeze_req = 1'b1;
        v = 16'($urandom);
        v = v >>> shift;
        send_sample(silent ? 16'sd0 : v, i == len - 1);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d blocks, full-scale and silent blocks included,",
             sb.n_samples, sb.n_blocks);
    $display("with levels from %0d to %0d in 1/256 dB and %0d mismatches.",
             sb.lowest, sb.highest, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
